FILE: rtl/sfd_pkg.sv
// Shared types, constants and helper functions for the serial link frame deframer.
// No dependencies; every other file in rtl/ except sfd_ram imports this package.
`timescale 1ns / 1ps

package sfd_pkg;

    // Frame geometry
    localparam int MAX_FRAME_BYTES = 64;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int TOT_W           = 9;
    localparam int RAM_DEPTH       = 2 * MAX_FRAME_BYTES;
    localparam int RAM_AW          = $clog2(RAM_DEPTH);
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    // Output field widths
    localparam int STATUS_W = 2;
    localparam int PLEN_W   = 6;
    localparam int DATA_W   = 8;

    localparam int LEN_MIN  = 2;
    localparam int LEN_MAX  = MAX_FRAME_BYTES - 2;

    // Byte positions inside a frame
    localparam int POS_TYPE = 2;
    localparam int POS_DST  = 3;
    localparam int POS_SRC  = 4;

    // Header bytes counted in the declared length, and payload start
    localparam logic [7:0] STD_HDR       = 8'd2;
    localparam logic [7:0] EXT_HDR       = 8'd4;
    localparam logic [7:0] STD_START     = 8'd3;
    localparam logic [7:0] EXT_START     = 8'd5;

    localparam logic [7:0] CRC_POLY      = 8'hD5;

    // Accepted sync addresses
    localparam logic [7:0] ADDR_FC       = 8'hC8;
    localparam logic [7:0] ADDR_BCAST    = 8'h00;
    localparam logic [7:0] ADDR_RX       = 8'hEA;
    localparam logic [7:0] ADDR_TX       = 8'hEE;
    localparam logic [7:0] ADDR_RX_ALT   = 8'hEC;

    // Types at or above EXT_TYPE_MIN carry dest/src, except these
    localparam logic [7:0] EXT_TYPE_MIN  = 8'h28;
    localparam logic [7:0] TYPE_X34      = 8'h34;
    localparam logic [7:0] TYPE_X80      = 8'h80;
    localparam logic [7:0] TYPE_X81      = 8'h81;
    localparam logic [7:0] TYPE_X82      = 8'h82;
    localparam logic [7:0] TYPE_X88      = 8'h88;
    localparam logic [7:0] TYPE_XAA      = 8'hAA;
    localparam logic [7:0] TYPE_XAC      = 8'hAC;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CRC   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;

    // Frame descriptor handed from front to back
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          sync_addr;
        logic [7:0]          frame_type;
        logic                is_ext;
        logic [7:0]          dest_addr;
        logic [7:0]          src_addr;
        logic [POS_W-1:0]    plen;
        logic [POS_W-1:0]    start;
        logic                bank;
    } t_desc;

    // One result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          sync_addr;
        logic [7:0]          frame_type;
        logic                is_ext;
        logic [7:0]          dest_addr;
        logic [7:0]          src_addr;
        logic [PLEN_W-1:0]   pay_count;
        logic [PLEN_W-1:0]   byte_index;
        logic [7:0]          payload_byte;
        logic                byte_valid;
        logic                last;
    } t_result;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_ADDR,
        BS_READ,
        BS_OUT
    } t_back_state;

    function automatic logic addr_ok(input logic [7:0] b);
        return (b == ADDR_FC) || (b == ADDR_BCAST) || (b == ADDR_RX) ||
               (b == ADDR_TX) || (b == ADDR_RX_ALT);
    endfunction

    function automatic logic type_ext(input logic [7:0] t);
        logic excl;
        excl = (t == TYPE_X34) || (t == TYPE_X80) || (t == TYPE_X81) ||
               (t == TYPE_X82) || (t == TYPE_X88) || (t == TYPE_XAA) ||
               (t == TYPE_XAC);
        return (t >= EXT_TYPE_MIN) && !excl;
    endfunction

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        c = crc ^ d;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/sfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sfd_front.sv
// Front end: sync hunt, length check, CRC and frame store writes.
// Emits one descriptor per completed frame. Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_front import sfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    output logic              o_we,
    output logic [RAM_AW-1:0] o_waddr,
    output logic [7:0]        o_wdata,
    output logic              o_push,
    output t_desc             o_desc
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_crc, n_crc;
    logic [7:0]       r_sync, n_sync;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_dst, n_dst;
    logic [7:0]       r_src, n_src;
    logic             r_bank, n_bank;

    logic [TOT_W-1:0] total;
    logic [TOT_W-1:0] cnt_x;
    logic             crc_ok;
    logic             ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_len  <= '0;
            r_crc  <= '0;
            r_bank <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_len  <= n_len;
            r_crc  <= n_crc;
            r_bank <= n_bank;
        end
        r_sync <= n_sync;
        r_type <= n_type;
        r_dst  <= n_dst;
        r_src  <= n_src;
    end

    assign total   = TOT_W'(r_len) + TOT_W'(2);
    assign cnt_x   = TOT_W'(r_cnt);
    assign crc_ok  = (r_crc == i_rx_byte);
    assign ext     = type_ext(r_type);
    assign o_waddr = {r_bank, r_cnt[POS_W-1:0]};
    assign o_wdata = i_rx_byte;

    // Descriptor for a frame closed by the current byte
    always_comb begin
        o_desc.sync_addr  = r_sync;
        o_desc.frame_type = r_type;
        o_desc.bank       = r_bank;
        o_desc.dest_addr  = '0;
        o_desc.src_addr   = '0;
        o_desc.plen       = '0;
        o_desc.start      = POS_W'(STD_START);
        if (!crc_ok) begin
            o_desc.status = ST_CRC;
            o_desc.is_ext = 1'b0;
        end else if (ext && (r_len < EXT_HDR)) begin
            o_desc.status = ST_SHORT;
            o_desc.is_ext = 1'b1;
        end else begin
            o_desc.status = ST_OK;
            o_desc.is_ext = ext;
            if (ext) begin
                o_desc.dest_addr = r_dst;
                o_desc.src_addr  = r_src;
                o_desc.plen      = POS_W'(r_len - EXT_HDR);
                o_desc.start     = POS_W'(EXT_START);
            end else begin
                o_desc.plen      = POS_W'(r_len - STD_HDR);
            end
        end
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_len  = r_len;
        n_crc  = r_crc;
        n_sync = r_sync;
        n_type = r_type;
        n_dst  = r_dst;
        n_src  = r_src;
        n_bank = r_bank;
        o_we   = 1'b0;
        o_push = 1'b0;
        if (i_accept) begin
            if (r_cnt == '0) begin
                if (addr_ok(i_rx_byte)) begin
                    n_sync = i_rx_byte;
                    n_cnt  = CNT_W'(1);
                end
            end else if (r_cnt == CNT_W'(1)) begin
                n_len = i_rx_byte;
                n_crc = '0;
                if ((TOT_W'(i_rx_byte) < TOT_W'(LEN_MIN)) ||
                    (TOT_W'(i_rx_byte) > TOT_W'(LEN_MAX))) begin
                    n_cnt = '0;
                end else begin
                    n_cnt = CNT_W'(2);
                end
            end else if ((cnt_x >= TOT_W'(MAX_FRAME_BYTES)) || (cnt_x >= total)) begin
                n_cnt = '0;
            end else begin
                o_we = 1'b1;
                if (cnt_x + TOT_W'(1) < total) begin
                    n_crc = crc8_step(r_crc, i_rx_byte);
                    n_cnt = r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(POS_TYPE)) begin
                        n_type = i_rx_byte;
                    end
                    if (r_cnt == CNT_W'(POS_DST)) begin
                        n_dst = i_rx_byte;
                    end
                    if (r_cnt == CNT_W'(POS_SRC)) begin
                        n_src = i_rx_byte;
                    end
                end else begin
                    // CRC byte closes the frame
                    n_cnt  = '0;
                    o_push = 1'b1;
                    n_bank = ~r_bank;
                end
            end
        end
    end

endmodule

FILE: rtl/sfd_queue.sv
// Two-entry descriptor queue between front and back.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_queue import sfd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output t_desc o_head,
    output logic  o_full,
    output logic  o_empty
);

    t_desc             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
        if (do_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

endmodule

FILE: rtl/sfd_back.sv
// Back end: walks the head descriptor and emits its result run from the store.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_back import sfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_desc             i_head,
    input  logic [7:0]        i_rdata,
    output logic [RAM_AW-1:0] o_raddr,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output t_result           o_res
);

    t_back_state      r_state, n_state;
    logic [POS_W-1:0] r_k, n_k;
    t_result          r_out, n_out;
    logic [POS_W-1:0] pos;

    assign pos     = i_head.start + r_k;
    assign o_raddr = {i_head.bank, pos};
    assign o_valid = (r_state == BS_OUT);
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_out <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_out   = r_out;
        o_pop   = 1'b0;
        case (r_state)
            BS_IDLE: begin
                n_k = '0;
                n_out.status       = i_head.status;
                n_out.sync_addr    = i_head.sync_addr;
                n_out.frame_type   = i_head.frame_type;
                n_out.is_ext       = i_head.is_ext;
                n_out.dest_addr    = i_head.dest_addr;
                n_out.src_addr     = i_head.src_addr;
                n_out.pay_count    = '0;
                n_out.byte_index   = '0;
                n_out.payload_byte = '0;
                n_out.byte_valid   = 1'b0;
                n_out.last         = 1'b1;
                if (!i_empty) begin
                    // errors and empty payloads make a single result
                    n_state = (i_head.plen == '0) ? BS_OUT : BS_ADDR;
                end
            end
            BS_ADDR: begin
                n_state = BS_READ;
            end
            BS_READ: begin
                n_out.pay_count    = PLEN_W'(i_head.plen);
                n_out.byte_index   = PLEN_W'(r_k);
                n_out.payload_byte = i_rdata;
                n_out.byte_valid   = 1'b1;
                n_out.last = ((POS_W + 1)'(r_k) + (POS_W + 1)'(1)) ==
                             (POS_W + 1)'(i_head.plen);
                n_state = BS_OUT;
            end
            BS_OUT: begin
                if (i_ready) begin
                    if (r_out.last) begin
                        o_pop   = 1'b1;
                        n_state = BS_IDLE;
                    end else begin
                        n_k     = r_k + POS_W'(1);
                        n_state = BS_ADDR;
                    end
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/serial_link_frame_deframer.sv
// Serial link frame deframer: one received byte per transfer in, payload runs out.
// A status-only result is loaded from the queue head straight into the output register.
// Throughput: one input byte per cycle while the two-entry descriptor queue has room;
// each payload result passes the store address, store read and output register states in turn.
// Reset (i_rst_n, synchronous, active low) returns the front to sync hunt and empties the queue.
// Depends on sfd_pkg, sfd_ram, sfd_front, sfd_queue, sfd_back.
`timescale 1ns / 1ps

module serial_link_frame_deframer import sfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // receive byte stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] status, [9:2] sync_addr, [17:10] frame_type, [18] is_extended,
    // [26:19] dest_addr, [34:27] src_addr, [40:35] pay_count,
    // [46:41] byte_index, [54:47] payload_byte, [55] zero
    output logic [55:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser,   // [0] byte_valid
    output logic        o_m_axis_tlast    // last
);

    logic              in_xfer;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [RAM_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    t_desc             front_desc;
    t_desc             q_head;
    t_result           res;

    // The front keeps taking bytes until both queue slots hold frames; the
    // store is two banks, so the frame being emitted is never overwritten.
    assign o_s_axis_tready = !q_full;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    sfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_xfer),
        .i_rx_byte (i_s_axis_tdata),
        .o_we      (ram_we),
        .o_waddr   (ram_waddr),
        .o_wdata   (ram_wdata),
        .o_push    (q_push),
        .o_desc    (front_desc)
    );

    // Frame store: bank bit on top, byte position below
    sfd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A descriptor stays at the head until its last result transfers,
    // which keeps its bank reserved for the whole run.
    sfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (front_desc),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    sfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (q_head),
        .i_rdata (ram_rdata),
        .o_raddr (ram_raddr),
        .o_pop   (q_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

    // Output packing, first field in the low bits
    assign o_m_axis_tdata = {1'b0, res.payload_byte, res.byte_index, res.pay_count,
                             res.src_addr, res.dest_addr, res.is_ext,
                             res.frame_type, res.sync_addr, res.status};
    assign o_m_axis_tuser = res.byte_valid;
    assign o_m_axis_tlast = res.last;

    // The front only closes a frame when the queue has a free slot
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("descriptor pushed into a full queue");

    // A status-only result is always the whole run
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("status-only result not marked last");

    // Payload bytes come only from good frames and stay inside the payload
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
            (res.status == ST_OK) && (res.byte_index < res.pay_count))
        else $error("payload byte outside a good frame");

    // The queue is popped exactly on the transfer of a run's last result
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast))
        else $error("queue popped outside a final transfer");

endmodule

FILE: verif/tb_top.sv
// Self-checking bench for serial_link_frame_deframer: byte stream in, payload runs out.
// Holds its own frame tracker and payload scoreboard; depends on sfd_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_top;
    import sfd_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 40;
    localparam int HOLD_CYCLES  = 400;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SLUGGISH,
        RX_PERIODIC
    } t_rx_mode;

    // Tracks the deframer state byte by byte and keeps the results each frame should produce.
    class deframe_tracker;
        int unsigned  count;
        int unsigned  decl_len;
        logic [7:0]   crc;
        logic [7:0]   store [MAX_FRAME_BYTES];
        t_result      pending [$];
        int unsigned  errors;

        function new();
            count    = 0;
            decl_len = 0;
            crc      = 8'h00;
            errors   = 0;
        endfunction

        static function logic is_sync(logic [7:0] b);
            return b == ADDR_FC || b == ADDR_BCAST || b == ADDR_RX ||
                   b == ADDR_TX || b == ADDR_RX_ALT;
        endfunction

        static function logic is_ext_type(logic [7:0] t);
            if (t < EXT_TYPE_MIN) return 1'b0;
            return !(t == TYPE_X34 || t == TYPE_X80 || t == TYPE_X81 || t == TYPE_X82 ||
                     t == TYPE_X88 || t == TYPE_XAA || t == TYPE_XAC);
        endfunction

        // CRC-8, MSB first
        static function logic [7:0] crc_next(logic [7:0] c, logic [7:0] d);
            logic [7:0] r;
            r = c ^ d;
            for (int i = 0; i < 8; i++) begin
                r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
            end
            return r;
        endfunction

        function void push_result(logic [1:0] st, logic ext, logic [7:0] dst, logic [7:0] src,
                                  int unsigned plen, int unsigned idx, logic [7:0] pb,
                                  logic valid, logic last);
            t_result r;
            r.status       = st;
            r.sync_addr    = store[0];
            r.frame_type   = store[POS_TYPE];
            r.is_ext       = ext;
            r.dest_addr    = dst;
            r.src_addr     = src;
            r.pay_count    = plen[PLEN_W-1:0];
            r.byte_index   = idx[PLEN_W-1:0];
            r.payload_byte = pb;
            r.byte_valid   = valid;
            r.last         = last;
            pending.push_back(r);
        endfunction

        // Called once per accepted input transfer
        function void absorb_byte(logic [7:0] b);
            int unsigned total;
            int unsigned start;
            int unsigned plen;
            logic        ext;
            logic [7:0]  dst;
            logic [7:0]  src;
            if (count == 0) begin
                if (is_sync(b)) begin
                    store[0] = b;
                    count    = 1;
                end
                return;
            end
            if (count == 1) begin
                store[1] = b;
                decl_len = b;
                crc      = 8'h00;
                count    = (b < LEN_MIN || b > LEN_MAX) ? 0 : 2;
                return;
            end
            total = decl_len + 2;
            if (count >= MAX_FRAME_BYTES || count >= total) begin
                count = 0;
                return;
            end
            store[count] = b;
            if (count + 1 < total) begin
                crc = crc_next(crc, b);
                count++;
                return;
            end
            // b is the received CRC
            count = 0;
            if (crc != b) begin
                push_result(ST_CRC, 1'b0, 8'h00, 8'h00, 0, 0, 8'h00, 1'b0, 1'b1);
                return;
            end
            ext = is_ext_type(store[POS_TYPE]);
            if (ext && decl_len < EXT_HDR) begin
                push_result(ST_SHORT, 1'b1, 8'h00, 8'h00, 0, 0, 8'h00, 1'b0, 1'b1);
                return;
            end
            start = ext ? EXT_START : STD_START;
            plen  = decl_len - (ext ? EXT_HDR : STD_HDR);
            dst   = ext ? store[POS_DST] : 8'h00;
            src   = ext ? store[POS_SRC] : 8'h00;
            if (plen == 0) begin
                push_result(ST_OK, ext, dst, src, 0, 0, 8'h00, 1'b0, 1'b1);
                return;
            end
            for (int k = 0; k < plen; k++) begin
                push_result(ST_OK, ext, dst, src, plen, k, store[start + k], 1'b1,
                            k + 1 == plen);
            end
        endfunction

        function void cmp(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // Called once per accepted output transfer
        function void match_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $error("result with nothing pending: status %0d index %0d byte 0x%0h",
                       got.status, got.byte_index, got.payload_byte);
                errors++;
                return;
            end
            want = pending.pop_front();
            cmp("status",       want.status,       got.status);
            cmp("sync_addr",    want.sync_addr,    got.sync_addr);
            cmp("frame_type",   want.frame_type,   got.frame_type);
            cmp("is_extended",  want.is_ext,       got.is_ext);
            cmp("dest_addr",    want.dest_addr,    got.dest_addr);
            cmp("src_addr",     want.src_addr,     got.src_addr);
            cmp("pay_count",    want.pay_count,    got.pay_count);
            cmp("byte_index",   want.byte_index,   got.byte_index);
            cmp("payload_byte", want.payload_byte, got.payload_byte);
            cmp("byte_valid",   want.byte_valid,   got.byte_valid);
            cmp("last",         want.last,         got.last);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        o_s_axis_tready;
    logic [7:0]  s_data;
    logic        o_m_axis_tvalid;
    logic        m_ready;
    logic [55:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;

    deframe_tracker sb;

    int unsigned cycles;
    int unsigned burst_left;
    int unsigned frame_bytes;
    logic        steady;      // sender offers back to back, no gaps
    logic        hold_req;
    logic        hold_done;
    int unsigned hold_left;
    int unsigned mode_left;
    t_rx_mode    rx_mode;
    logic        rdy_next;
    t_result     seen;

    logic [7:0] sync_set [5] = '{ADDR_FC, ADDR_BCAST, ADDR_RX, ADDR_TX, ADDR_RX_ALT};
    logic [7:0] plain_set [7] = '{TYPE_X34, TYPE_X80, TYPE_X81, TYPE_X82,
                                  TYPE_X88, TYPE_XAA, TYPE_XAC};

    serial_link_frame_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: check accepted transfers, then pick the next tready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && m_ready) begin
            seen.status       = o_m_axis_tdata[1:0];
            seen.sync_addr    = o_m_axis_tdata[9:2];
            seen.frame_type   = o_m_axis_tdata[17:10];
            seen.is_ext       = o_m_axis_tdata[18];
            seen.dest_addr    = o_m_axis_tdata[26:19];
            seen.src_addr     = o_m_axis_tdata[34:27];
            seen.pay_count    = o_m_axis_tdata[40:35];
            seen.byte_index   = o_m_axis_tdata[46:41];
            seen.payload_byte = o_m_axis_tdata[54:47];
            seen.byte_valid   = o_m_axis_tuser;
            seen.last         = o_m_axis_tlast;
            sb.match_result(seen);
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy_next = 1'b0;
        end else if (hold_req && !hold_done) begin
            // long back-pressure so the descriptor queue fills and input stalls
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rdy_next  = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(30, 200);
            end
            mode_left--;
            case (rx_mode)
                RX_ALWAYS:   rdy_next = 1'b1;
                RX_COIN:     rdy_next = 1'($urandom_range(0, 1));
                RX_SLUGGISH: rdy_next = ($urandom_range(0, 3) == 0);
                default:     rdy_next = (cycles % 5 != 0);
            endcase
        end
        m_ready <= rdy_next;
    end

    // One input transfer; idles between bursts unless steady is set
    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0 && !steady) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        if (burst_left > 0) burst_left--;
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        sb.absorb_byte(b);
    endtask

    task automatic send_frame(logic [7:0] addr, logic [7:0] len, logic [7:0] ftype,
                              logic good_crc);
        logic [7:0] c;
        logic [7:0] b;
        send_byte(addr);
        send_byte(len);
        c = deframe_tracker::crc_next(8'h00, ftype);
        send_byte(ftype);
        for (int n = 0; n < len - 2; n++) begin
            // sync values inside a frame must pass as plain data
            b = ($urandom_range(0, 7) == 0) ? sync_set[$urandom_range(0, 4)]
                                            : 8'($urandom_range(0, 255));
            c = deframe_tracker::crc_next(c, b);
            send_byte(b);
        end
        send_byte(good_crc ? c : c ^ 8'($urandom_range(1, 255)));
        frame_bytes += len + 2;
    endtask

    // Junk between frames: stray bytes or a sync with a rejected length
    task automatic send_noise();
        logic [7:0] b;
        if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                b = 8'($urandom_range(0, 255));
                if (deframe_tracker::is_sync(b)) b ^= 8'h01;
                send_byte(b);
            end
        end else begin
            send_byte(sync_set[$urandom_range(0, 4)]);
            send_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, LEN_MIN - 1))
                                                  : 8'($urandom_range(LEN_MAX + 1, 255)));
        end
    endtask

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 5))
            0:       return 8'($urandom_range(0, EXT_TYPE_MIN - 1));
            1:       return plain_set[$urandom_range(0, 6)];
            2:       return 8'($urandom_range(EXT_TYPE_MIN, 255));
            3:       return ($urandom_range(0, 1) == 0) ? EXT_TYPE_MIN - 8'd1 : EXT_TYPE_MIN;
            4:       return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [7:0] len;
        sb          = new();
        cycles      = 0;
        burst_left  = 0;
        frame_bytes = 0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        hold_left   = 0;
        mode_left   = 0;
        rx_mode     = RX_ALWAYS;
        i_rst_n     = 1'b0;
        s_valid     = 1'b0;
        s_data      = 8'h00;
        m_ready     = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: junk, rejected lengths, minimum frame, error and empty cases
        send_byte(8'hFF);
        send_byte(ADDR_BCAST);
        send_byte(8'd1);
        send_byte(ADDR_RX);
        send_byte(8'd63);
        send_frame(ADDR_FC, 8'd2, 8'h10, 1'b1);          // empty standard payload
        send_frame(ADDR_TX, 8'd3, EXT_TYPE_MIN, 1'b1);   // extended header cut short
        send_frame(ADDR_RX_ALT, 8'd2, TYPE_X81, 1'b0);   // crc mismatch
        send_frame(ADDR_FC, 8'd4, 8'h29, 1'b1);          // extended, no payload
        send_frame(ADDR_BCAST, 8'd5, 8'h16, 1'b1);

        // receiver holds off while frames keep coming back to back
        hold_req <= 1'b1;
        steady = 1'b1;
        repeat (6) send_frame(sync_set[$urandom_range(0, 4)], 8'($urandom_range(6, 10)),
                              8'h14, 1'b1);
        steady = 1'b0;

        // random part; longest standard and extended frames go first
        send_frame(ADDR_RX, 8'(LEN_MAX), TYPE_X34, 1'b1);
        send_frame(ADDR_FC, 8'(LEN_MAX), 8'hFF, 1'b1);
        frame_bytes = 0;
        while (frame_bytes < RANDOM_BYTES) begin
            if ($urandom_range(0, 4) == 0) send_noise();
            len = ($urandom_range(0, 11) == 0) ? 8'(LEN_MAX)
                                               : 8'($urandom_range(LEN_MIN, 12));
            send_frame(sync_set[$urandom_range(0, 4)], len, pick_type(),
                       $urandom_range(0, 6) != 0);
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sfd_pkg.sv
rtl/sfd_ram.sv
rtl/sfd_front.sv
rtl/sfd_queue.sv
rtl/sfd_back.sv
rtl/serial_link_frame_deframer.sv
verif/tb_top.sv
